>>> rtl/gdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdn_pkg;

	localparam int unsigned MAX_YEAR_DEF = 5000;

	localparam int unsigned DAYS_400Y = 146097;
	localparam int unsigned DAYS_100Y = 36524;
	localparam int unsigned DAYS_4Y   = 1461;
	localparam int unsigned DAYS_1Y   = 365;

	// 400y/4y: floor reciprocal, estimate exact or one low, fixed by one compare.
	localparam int unsigned RECIP_400Y = 29398;  // 2^32 / 146097
	localparam int unsigned RECIP_4Y   = 1435;   // 2^21 / 1461
	localparam int unsigned RECIP_100  = 5243;   // ceil(2^19 / 100), exact below 43699

	// Stages of the day number -> date path, and of the date -> day number path.
	localparam int unsigned GDN_LAT        = 10;
	localparam int unsigned GDN_D2N_STAGES = 3;

	typedef struct packed {
		logic [20:0] day_number;
		logic [12:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        leap;
		logic        err;
	} gdn_res_t;

	// Days before the first of a month, zero-based month index, common year.
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] s;
		case (idx)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gregorian_day_number_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Proleptic Gregorian date <-> serial day number converter (day 1 = 0001-01-01).
// Input transfer: start high at a rising edge while busy is low. busy is always
// low, so one item may be given in every cycle. op = 1 converts in_year,
// in_month, in_day to out_day_number; op = 0 converts in_day_number to
// out_year, out_month, out_day. is_leap reports the year's leap flag;
// range_error marks inputs outside the valid ranges, all other fields zero.
// Output transfer: done is high for exactly one cycle with the result fields;
// results leave in input order. Both directions run through a 10-stage pipeline
// (day number -> date: division by the 400-, 100-, 4- and 1-year cycle lengths,
// then month search; date -> day number is delayed to match) plus the output
// register, so throughput is one item per cycle. The receiver cannot stall.
// Reset clears the valid pipeline and done; items in flight are dropped.

module gregorian_day_number_converter_core #(
	parameter int unsigned MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [20:0] in_day_number,
	input  wire logic [12:0] in_year,
	input  wire logic [3:0]  in_month,
	input  wire logic [4:0]  in_day,
	output logic             done,
	output logic [20:0]      out_day_number,
	output logic [12:0]      out_year,
	output logic [3:0]       out_month,
	output logic [4:0]       out_day,
	output logic             is_leap,
	output logic             range_error
);
	import gdn_pkg::*;

	gdn_res_t d2n_res, n2d_res, sel_res;
	logic [GDN_LAT-1:0] pipe_vld_q, pipe_op_q;
	logic done_q;
	gdn_res_t out_q;

	assign busy = 1'b0;

	gdn_date2num #(
		.MAX_YEAR (MAX_YEAR)
	) u_date2num (
		.clk      (clk),
		.in_year  (in_year),
		.in_month (in_month),
		.in_day   (in_day),
		.res      (d2n_res)
	);

	gdn_num2date #(
		.MAX_YEAR (MAX_YEAR)
	) u_num2date (
		.clk           (clk),
		.in_day_number (in_day_number),
		.res           (n2d_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
			done_q     <= 1'b0;
		end else begin
			pipe_vld_q <= {pipe_vld_q[GDN_LAT-2:0], start & ~busy};
			done_q     <= pipe_vld_q[GDN_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		pipe_op_q <= {pipe_op_q[GDN_LAT-2:0], op};
	end

	assign sel_res = pipe_op_q[GDN_LAT-1] ? d2n_res : n2d_res;

	always_ff @(posedge clk) begin
		if (pipe_vld_q[GDN_LAT-1]) begin
			out_q <= sel_res;
		end
	end

	assign done           = done_q;
	assign out_day_number = out_q.day_number;
	assign out_year       = out_q.year;
	assign out_month      = out_q.month;
	assign out_day        = out_q.day;
	assign is_leap        = out_q.leap;
	assign range_error    = out_q.err;

endmodule

`default_nettype wire

>>> rtl/gdn_date2num.sv
`timescale 1ns / 1ps
`default_nettype none

module gdn_date2num #(
	parameter int unsigned MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
	input  wire logic             clk,
	input  wire logic [12:0]      in_year,
	input  wire logic [3:0]       in_month,
	input  wire logic [4:0]       in_day,
	output gdn_pkg::gdn_res_t     res
);
	import gdn_pkg::*;

	localparam int unsigned DLY = GDN_LAT - GDN_D2N_STAGES;

	// s1
	logic [12:0] y_s1, p_s1;
	logic [6:0]  pq_s1, yq_s1;
	logic [3:0]  m_s1;
	logic [4:0]  d_s1;
	logic        err_s1;
	// s2
	logic [21:0] base_s2;
	logic [8:0]  moff_s2;
	logic [4:0]  d_s2;
	logic        leap_s2, err_s2;
	// s3
	gdn_res_t    res_s3;

	logic [12:0] p_c;
	logic [25:0] pprod_c, yprod_c;
	logic [12:0] rem100_c;
	logic        leap_c;
	logic [21:0] v_c;
	gdn_res_t    res_c;

	assign p_c     = in_year - 13'd1;
	assign pprod_c = 26'(p_c) * 26'(RECIP_100);
	assign yprod_c = 26'(in_year) * 26'(RECIP_100);

	always_ff @(posedge clk) begin
		y_s1   <= in_year;
		p_s1   <= p_c;
		pq_s1  <= pprod_c[25:19];
		yq_s1  <= yprod_c[25:19];
		m_s1   <= in_month;
		d_s1   <= in_day;
		err_s1 <= (in_year == 13'd0) || (32'(in_year) > MAX_YEAR) ||
			(in_month == 4'd0) || (in_month > 4'd12) || (in_day == 5'd0);
	end

	assign rem100_c = y_s1 - 13'(yq_s1) * 13'd100;
	assign leap_c   = (y_s1[1:0] == 2'b00) && ((rem100_c != 13'd0) || (yq_s1[1:0] == 2'b00));

	always_ff @(posedge clk) begin
		base_s2 <= 22'(p_s1) * 22'(DAYS_1Y) + 22'(p_s1[12:2]) - 22'(pq_s1) + 22'(pq_s1[6:2]);
		moff_s2 <= month_start(m_s1 - 4'd1) + 9'((leap_c && (m_s1 > 4'd2)) ? 1 : 0);
		leap_s2 <= leap_c;
		d_s2    <= d_s1;
		err_s2  <= err_s1;
	end

	assign v_c = base_s2 + 22'(moff_s2) + 22'(d_s2);

	always_comb begin
		res_c = '0;
		if (err_s2 || v_c[21]) begin
			res_c.err = 1'b1;
		end else begin
			res_c.day_number = v_c[20:0];
			res_c.leap       = leap_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_c;
	end

	// Align with the longer day number -> date path.
	gdn_res_t dly_q [DLY];

	always_ff @(posedge clk) begin
		dly_q[0] <= res_s3;
		for (int i = 1; i < DLY; i++) begin
			dly_q[i] <= dly_q[i-1];
		end
	end

	assign res = dly_q[DLY-1];

endmodule

`default_nettype wire

>>> rtl/gdn_num2date.sv
`timescale 1ns / 1ps
`default_nettype none

module gdn_num2date #(
	parameter int unsigned MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
	input  wire logic             clk,
	input  wire logic [20:0]      in_day_number,
	output gdn_pkg::gdn_res_t     res
);
	import gdn_pkg::*;

	localparam int unsigned PY = MAX_YEAR - 1;
	localparam int unsigned LAST = PY * 365 + PY / 4 - PY / 100 + PY / 400 + 365 +
		((((MAX_YEAR % 4) == 0 && (MAX_YEAR % 100) != 0) || (MAX_YEAR % 400) == 0) ? 1 : 0);
	localparam logic [21:0] LAST_DN = 22'(LAST);

	// s1: 400-year estimate
	logic [20:0] r_s1;
	logic [3:0]  qe_s1;
	logic        err_s1;
	// s2
	logic [18:0] rem_s2;
	logic [3:0]  qe_s2;
	logic        err_s2;
	// s3: 400-year fix
	logic [17:0] r400_s3;
	logic [3:0]  q400_s3;
	logic        err_s3;
	// s4: 100-year
	logic [15:0] r100_s4;
	logic [1:0]  q100_s4;
	logic [3:0]  q400_s4;
	logic        err_s4;
	// s5: 4-year estimate
	logic [15:0] r100_s5;
	logic [4:0]  qe4_s5;
	logic [1:0]  q100_s5;
	logic [3:0]  q400_s5;
	logic        err_s5;
	// s6
	logic [11:0] rem4_s6;
	logic [4:0]  qe4_s6;
	logic [1:0]  q100_s6;
	logic [3:0]  q400_s6;
	logic        err_s6;
	// s7: 4-year fix
	logic [10:0] r4_s7;
	logic [4:0]  q4_s7;
	logic [1:0]  q100_s7;
	logic [3:0]  q400_s7;
	logic        err_s7;
	// s8: single year, year and leap
	logic [8:0]  doy_s8;
	logic [12:0] year_s8;
	logic        leap_s8, err_s8;
	// s9: month
	logic [8:0]  doy_s9, mst_s9;
	logic [3:0]  month_s9;
	logic [12:0] year_s9;
	logic        leap_s9, err_s9;
	// s10
	gdn_res_t    res_s10;

	logic [20:0] r_c;
	logic [35:0] prod400_c;
	logic [26:0] prod4_c;
	logic [1:0]  q100_c, q1_c;
	logic [3:0]  month_c;
	logic [8:0]  mst_c, st_c;
	gdn_res_t    res_c;

	assign r_c       = in_day_number - 21'd1;
	assign prod400_c = 36'(r_c) * 36'(RECIP_400Y);

	always_ff @(posedge clk) begin
		r_s1   <= r_c;
		qe_s1  <= prod400_c[35:32];
		err_s1 <= (in_day_number == 21'd0) || ({1'b0, in_day_number} > LAST_DN);
	end

	always_ff @(posedge clk) begin
		rem_s2 <= 19'(r_s1 - 21'(21'(qe_s1) * 21'(DAYS_400Y)));
		qe_s2  <= qe_s1;
		err_s2 <= err_s1;
	end

	always_ff @(posedge clk) begin
		if (rem_s2 >= 19'(DAYS_400Y)) begin
			q400_s3 <= qe_s2 + 4'd1;
			r400_s3 <= 18'(rem_s2 - 19'(DAYS_400Y));
		end else begin
			q400_s3 <= qe_s2;
			r400_s3 <= rem_s2[17:0];
		end
		err_s3 <= err_s2;
	end

	always_comb begin
		if (r400_s3 >= 18'(3 * DAYS_100Y))      q100_c = 2'd3;
		else if (r400_s3 >= 18'(2 * DAYS_100Y)) q100_c = 2'd2;
		else if (r400_s3 >= 18'(DAYS_100Y))     q100_c = 2'd1;
		else                                    q100_c = 2'd0;
	end

	always_ff @(posedge clk) begin
		q100_s4 <= q100_c;
		r100_s4 <= 16'(r400_s3 - 18'(18'(q100_c) * 18'(DAYS_100Y)));
		q400_s4 <= q400_s3;
		err_s4  <= err_s3;
	end

	assign prod4_c = 27'(r100_s4) * 27'(RECIP_4Y);

	always_ff @(posedge clk) begin
		r100_s5 <= r100_s4;
		qe4_s5  <= prod4_c[25:21];
		q100_s5 <= q100_s4;
		q400_s5 <= q400_s4;
		err_s5  <= err_s4;
	end

	always_ff @(posedge clk) begin
		rem4_s6 <= 12'(r100_s5 - 16'(16'(qe4_s5) * 16'(DAYS_4Y)));
		qe4_s6  <= qe4_s5;
		q100_s6 <= q100_s5;
		q400_s6 <= q400_s5;
		err_s6  <= err_s5;
	end

	always_ff @(posedge clk) begin
		if (rem4_s6 >= 12'(DAYS_4Y)) begin
			q4_s7 <= qe4_s6 + 5'd1;
			r4_s7 <= 11'(rem4_s6 - 12'(DAYS_4Y));
		end else begin
			q4_s7 <= qe4_s6;
			r4_s7 <= rem4_s6[10:0];
		end
		q100_s7 <= q100_s6;
		q400_s7 <= q400_s6;
		err_s7  <= err_s6;
	end

	always_comb begin
		if (r4_s7 >= 11'(3 * DAYS_1Y))      q1_c = 2'd3;
		else if (r4_s7 >= 11'(2 * DAYS_1Y)) q1_c = 2'd2;
		else if (r4_s7 >= 11'(DAYS_1Y))     q1_c = 2'd1;
		else                                q1_c = 2'd0;
	end

	always_ff @(posedge clk) begin
		doy_s8  <= 9'(r4_s7 - 11'(11'(q1_c) * 11'(DAYS_1Y)));
		year_s8 <= 13'(q400_s7) * 13'd400 + 13'(q100_s7) * 13'd100 +
			13'(q4_s7) * 13'd4 + 13'(q1_c) + 13'd1;
		leap_s8 <= (q1_c == 2'd3) && ((q4_s7 != 5'd24) || (q100_s7 == 2'd3));
		err_s8  <= err_s7;
	end

	always_comb begin
		month_c = 4'd1;
		mst_c   = 9'd0;
		st_c    = 9'd0;
		for (int k = 1; k < 12; k++) begin
			st_c = month_start(4'(k)) + 9'((leap_s8 && k >= 2) ? 1 : 0);
			if (doy_s8 >= st_c) begin
				month_c = 4'(k + 1);
				mst_c   = st_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		doy_s9   <= doy_s8;
		mst_s9   <= mst_c;
		month_s9 <= month_c;
		year_s9  <= year_s8;
		leap_s9  <= leap_s8;
		err_s9   <= err_s8;
	end

	always_comb begin
		res_c = '0;
		if (err_s9) begin
			res_c.err = 1'b1;
		end else begin
			res_c.year  = year_s9;
			res_c.month = month_s9;
			res_c.day   = 5'(doy_s9 - mst_s9 + 9'd1);
			res_c.leap  = leap_s9;
		end
	end

	always_ff @(posedge clk) begin
		res_s10 <= res_c;
	end

	assign res = res_s10;

endmodule

`default_nettype wire

>>> tb/gdn_test_pkg.sv
`timescale 1ns / 1ps

package gdn_test_pkg;

	localparam logic OP_TO_DATE       = 1'b0;
	localparam logic OP_TO_DAY_NUMBER = 1'b1;

	function automatic bit leap_year_of(input int unsigned yr);
		return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
	endfunction

	// Day number of Dec 31 of the year before yr.
	function automatic int unsigned days_ahead_of(input int unsigned yr);
		int unsigned p;
		p = yr - 1;
		return p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

endpackage

>>> tb/gdn_conversion_checker.sv
`timescale 1ns / 1ps

module gdn_conversion_checker #(
	parameter int unsigned MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        op,
	input  logic [20:0] in_day_number,
	input  logic [12:0] in_year,
	input  logic [3:0]  in_month,
	input  logic [4:0]  in_day,
	input  logic        done,
	input  logic [20:0] out_day_number,
	input  logic [12:0] out_year,
	input  logic [3:0]  out_month,
	input  logic [4:0]  out_day,
	input  logic        is_leap,
	input  logic        range_error,
	output int unsigned mismatches,
	output int unsigned awaited
);

	import gdn_pkg::gdn_res_t;
	import gdn_test_pkg::*;

	localparam int unsigned MONTH_OFFSET [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int unsigned PRINT_CAP = 100;

	gdn_res_t    pending_conversions [$];
	gdn_res_t    oldest;
	int unsigned fail_total = 0;
	int unsigned queued = 0;

	assign mismatches = fail_total;
	assign awaited    = queued;

	function automatic gdn_res_t convert(input logic dir, input logic [20:0] dn,
			input logic [12:0] y, input logic [3:0] m, input logic [4:0] d);
		gdn_res_t    res;
		int unsigned yv, mv, dv, total, last, rest, c400, c100, c4, c1, yr, mon;
		bit          lp;
		res = '0;
		yv = y;
		mv = m;
		dv = d;
		if (dir == OP_TO_DAY_NUMBER) begin
			if (yv < 1 || yv > MAX_YEAR || mv < 1 || mv > 12 || dv < 1) begin
				res.err = 1'b1;
			end else begin
				lp = leap_year_of(yv);
				total = days_ahead_of(yv) + MONTH_OFFSET[mv - 1] + ((lp && mv > 2) ? 1 : 0) + dv;
				if (total > 32'h1FFFFF) begin
					res.err = 1'b1;
				end else begin
					res.day_number = total[20:0];
					res.leap = lp;
				end
			end
		end else begin
			last = days_ahead_of(MAX_YEAR) + 365 + (leap_year_of(MAX_YEAR) ? 1 : 0);
			if (dn < 1 || dn > last) begin
				res.err = 1'b1;
			end else begin
				rest = dn - 1;
				c400 = rest / 146097;
				rest = rest % 146097;
				c100 = rest / 36524;
				if (c100 > 3)
					c100 = 3;
				rest = rest - c100 * 36524;
				c4 = rest / 1461;
				rest = rest % 1461;
				c1 = rest / 365;
				if (c1 > 3)
					c1 = 3;
				rest = rest - c1 * 365;
				yr = c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1;
				lp = leap_year_of(yr);
				mon = 1;
				for (int k = 1; k < 12; k++) begin
					if (rest >= MONTH_OFFSET[k] + ((lp && k >= 2) ? 1 : 0))
						mon = k + 1;
				end
				res.year = yr[12:0];
				res.month = mon[3:0];
				res.day = 5'(rest - (MONTH_OFFSET[mon - 1] + ((lp && mon > 2) ? 1 : 0)) + 1);
				res.leap = lp;
			end
		end
		return res;
	endfunction

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		if (fail_total < PRINT_CAP)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_conversions.delete();
			queued <= 0;
		end else begin
			if (done) begin
				if (pending_conversions.size() == 0) begin
					report("unexpected transfer", 1, 0);
				end else begin
					oldest = pending_conversions.pop_front();
					if (out_day_number !== oldest.day_number)
						report("out_day_number", out_day_number, oldest.day_number);
					if (out_year !== oldest.year)
						report("out_year", out_year, oldest.year);
					if (out_month !== oldest.month)
						report("out_month", out_month, oldest.month);
					if (out_day !== oldest.day)
						report("out_day", out_day, oldest.day);
					if (is_leap !== oldest.leap)
						report("is_leap", is_leap, oldest.leap);
					if (range_error !== oldest.err)
						report("range_error", range_error, oldest.err);
				end
			end
			if (start && !busy)
				pending_conversions.push_back(convert(op, in_day_number, in_year, in_month,
					in_day));
			queued <= pending_conversions.size();
		end
	end

endmodule

>>> tb/gregorian_day_number_converter_core_test.sv
`timescale 1ns / 1ps

module gregorian_day_number_converter_core_test;

	import gdn_test_pkg::*;

	localparam int unsigned MAX_YEAR    = gdn_pkg::MAX_YEAR_DEF;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 375;

	typedef struct {
		logic        op;
		logic [20:0] day_number;
		logic [12:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} conv_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = OP_TO_DATE;
	logic [20:0] in_day_number = '0;
	logic [12:0] in_year = '0;
	logic [3:0]  in_month = '0;
	logic [4:0]  in_day = '0;
	logic        busy;
	logic        done;
	logic [20:0] out_day_number;
	logic [12:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic        is_leap;
	logic        range_error;
	int unsigned mismatches;
	int unsigned awaited;
	int unsigned quiet_cycles = 0;
	int unsigned idle_pct [4] = '{0, 56, 0, 29};

	always #4 clk = ~clk;

	gregorian_day_number_converter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.in_day_number(in_day_number),
		.in_year(in_year),
		.in_month(in_month),
		.in_day(in_day),
		.done(done),
		.out_day_number(out_day_number),
		.out_year(out_year),
		.out_month(out_month),
		.out_day(out_day),
		.is_leap(is_leap),
		.range_error(range_error)
	);

	gdn_conversion_checker #(.MAX_YEAR(MAX_YEAR)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.in_day_number(in_day_number),
		.in_year(in_year),
		.in_month(in_month),
		.in_day(in_day),
		.done(done),
		.out_day_number(out_day_number),
		.out_year(out_year),
		.out_month(out_month),
		.out_day(out_day),
		.is_leap(is_leap),
		.range_error(range_error),
		.mismatches(mismatches),
		.awaited(awaited)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL gregorian_day_number_converter_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic conv_request_t date_req(input int unsigned y, input int unsigned m,
			input int unsigned d);
		conv_request_t rq;
		rq.op = OP_TO_DAY_NUMBER;
		rq.day_number = '1;
		rq.year = y[12:0];
		rq.month = m[3:0];
		rq.day = d[4:0];
		return rq;
	endfunction

	function automatic conv_request_t number_req(input int unsigned dn);
		conv_request_t rq;
		rq.op = OP_TO_DATE;
		rq.day_number = dn[20:0];
		rq.year = '1;
		rq.month = '1;
		rq.day = '1;
		return rq;
	endfunction

	function automatic conv_request_t random_request();
		conv_request_t rq;
		int unsigned   kind, y, last, dn;
		kind = $urandom_range(99, 0);
		last = days_ahead_of(MAX_YEAR + 1);
		rq.op = 1'($urandom_range(1, 0));
		rq.day_number = 21'($urandom);
		rq.year = 13'($urandom);
		rq.month = 4'($urandom);
		rq.day = 5'($urandom);
		if (rq.op == OP_TO_DAY_NUMBER) begin
			if (kind < 88) begin
				if (kind < 80)
					y = $urandom_range(MAX_YEAR, 1);
				else if (kind < 84)
					y = $urandom_range(8, 1);
				else
					y = MAX_YEAR - $urandom_range(3, 0);
				rq.year = y[12:0];
				rq.month = 4'($urandom_range(12, 1));
				rq.day = 5'($urandom_range(31, 1));
			end
		end else begin
			if (kind < 70) begin
				dn = $urandom_range(last, 1);
			end else if (kind < 85) begin
				y = $urandom_range(MAX_YEAR, 1);
				dn = days_ahead_of(y) + (kind[0] ? $urandom_range(2, 0) : $urandom_range(61, 58));
			end else if (kind < 92) begin
				dn = last - 1 + $urandom_range(2, 0);
			end else begin
				dn = $urandom;
			end
			rq.day_number = dn[20:0];
		end
		return rq;
	endfunction

	task automatic transfer(input conv_request_t rq);
		start <= 1'b1;
		op <= rq.op;
		in_day_number <= rq.day_number;
		in_year <= rq.year;
		in_month <= rq.month;
		in_day <= rq.day;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (awaited != 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		transfer(date_req(1, 1, 1));
		transfer(date_req(MAX_YEAR, 12, 31));
		transfer(date_req(2000, 2, 29));
		transfer(date_req(2000, 2, 31));
		transfer(date_req(2000, 3, 1));
		transfer(date_req(1900, 3, 1));
		transfer(date_req(400, 12, 31));
		transfer(date_req(1600, 12, 31));
		transfer(date_req(4, 12, 31));
		transfer(date_req(0, 1, 1));
		transfer(date_req(MAX_YEAR + 1, 1, 1));
		transfer(date_req(8191, 12, 31));
		transfer(date_req(2024, 0, 10));
		transfer(date_req(2024, 13, 1));
		transfer(date_req(2024, 15, 31));
		transfer(date_req(2024, 6, 0));
		transfer(number_req(0));
		transfer(number_req(1));
		transfer(number_req(60));
		transfer(number_req(1461));
		transfer(number_req(36524));
		transfer(number_req(146096));
		transfer(number_req(146097));
		transfer(number_req(days_ahead_of(MAX_YEAR + 1)));
		transfer(number_req(days_ahead_of(MAX_YEAR + 1) + 1));
		transfer(number_req('h1FFFFF));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				transfer(random_request());
				if (i != PHASE_ITEMS - 1 && $urandom_range(99, 0) < idle_pct[ph]) begin
					start <= 1'b0;
					repeat ($urandom_range(4, 1)) @(posedge clk);
				end
			end
			drain();
		end

		repeat (gdn_pkg::GDN_LAT + 8) @(posedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("PASS gregorian_day_number_converter_core");
		end else begin
			$display("FAIL gregorian_day_number_converter_core");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/gdn_pkg.sv
rtl/gdn_date2num.sv
rtl/gdn_num2date.sv
rtl/gregorian_day_number_converter_core.sv
tb/gdn_test_pkg.sv
tb/gdn_conversion_checker.sv
tb/gregorian_day_number_converter_core_test.sv
